### rtl/core/sfcf_pkg.sv
// shared types, constants and rounding helper for the stereo feedback comb filter
package sfcf_pkg;

    // sample and configuration field widths
    localparam int SAMPLE_W = 16;
    localparam int DELAY_W  = 12;
    localparam int COEF_W   = 16;
    localparam int FRAC     = 15;
    localparam int ACC_W    = 2 * SAMPLE_W + 3;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // register map, index is paddr[3:2]
    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_DELAY  = 2'd1;
    localparam logic [1:0] REG_FB     = 2'd2;
    localparam logic [1:0] REG_MIX    = 2'd3;

    // reset values
    localparam logic               RST_ENABLE = 1'b1;
    localparam logic [DELAY_W-1:0] RST_DELAY  = 12'd120;
    localparam logic [COEF_W-1:0]  RST_FB     = 16'd16384;
    localparam logic [COEF_W-1:0]  RST_MIX    = 16'd16384;

    // coefficient limits: feedback within +-0.97, mix at most one
    localparam logic signed [COEF_W-1:0] FB_LIMIT     = 16'sd31785;
    localparam logic signed [COEF_W-1:0] FB_LIMIT_NEG = -16'sd31785;
    localparam logic [COEF_W-1:0]        UNITY        = 16'h8000;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        t_sample left_in;
        t_sample right_in;
    } t_in_item;

    typedef struct packed {
        t_sample left_out;
        t_sample right_out;
    } t_out_item;

    // round half up at the binary point, then saturate to the sample range
    function automatic t_sample round_sat(input logic signed [ACC_W-1:0] v);
        localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC - 1);
        localparam logic signed [ACC_W-FRAC-1:0] Q_MAX =
            (ACC_W-FRAC)'((1 << (SAMPLE_W - 1)) - 1);
        localparam logic signed [ACC_W-FRAC-1:0] Q_MIN = ~Q_MAX;
        logic signed [ACC_W-1:0]      t;
        logic signed [ACC_W-FRAC-1:0] q;
        t_sample                      r;
        t = v + HALF;
        q = t[ACC_W-1:FRAC];
        if (q > Q_MAX) begin
            r = Q_MAX[SAMPLE_W-1:0];
        end else if (q < Q_MIN) begin
            r = Q_MIN[SAMPLE_W-1:0];
        end else begin
            r = q[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/stereo_feedback_comb_filter_top.sv
// stereo feedback comb filter: delay memories, multiply pipeline and register port
//
// Input channel i_in_valid / o_in_stall carries one stereo sample pair per request;
// output channel o_out_valid / i_out_stall returns one filtered pair per request,
// in order. Coefficients are written through the APB-style port while idle.
//
// Pipeline: accept (delay memory read issued), multiply, round/saturate with
// write-back into the delay memory, output register. Throughput is one request
// per cycle for delays of three or more while the receiver does not stall. With a
// delay of one or two the read of an entry waits for the write-back of the sample
// that feeds it: with a delay of one a request is not taken until the one before
// it is written back, and with a delay of two it waits while the request two places
// before it is still in the round stage.
//
// After reset both delay memories are swept to zero, one entry per cycle, and
// o_in_stall stays high meanwhile. Register writes are
// taken at any time. When the receiver stalls, the output register holds its
// result, the pipeline keeps filling, and o_in_stall rises once it is full.
module stereo_feedback_comb_filter_top #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  sfcf_pkg::t_in_item           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output sfcf_pkg::t_out_item          o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sfcf_pkg::ADDR_W-1:0]  paddr,
    input  logic [sfcf_pkg::DATA_W-1:0]  pwdata,
    output logic [sfcf_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import sfcf_pkg::*;

    localparam int PW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = (PW > DELAY_W) ? PW : DELAY_W;
    localparam logic [CW-1:0] D_MAX    = CW'(STORE_DEPTH - 1);
    localparam logic [PW-1:0] LAST_POS = PW'(STORE_DEPTH - 1);
    localparam logic [PW:0]   DEPTH_X  = (PW+1)'(STORE_DEPTH);

    // configuration registers
    logic                      r_enable;
    logic [DELAY_W-1:0]        r_delay;
    logic signed [COEF_W-1:0]  r_fb;
    logic [COEF_W-1:0]         r_mix;
    logic                      w_cfg_wr;
    logic [1:0]                w_cfg_idx;

    // delay memories
    t_sample                   r_mem_l [STORE_DEPTH];
    t_sample                   r_mem_r [STORE_DEPTH];
    t_sample                   r_rd_l;
    t_sample                   r_rd_r;
    logic                      w_we;
    logic [PW-1:0]             w_wa;
    t_sample                   w_wd_l;
    t_sample                   w_wd_r;

    // clearing sweep
    logic                      r_clr_busy;
    logic [PW-1:0]             r_clr_idx;
    logic [PW-1:0]             n_clr_idx;

    // position and read address
    logic [PW-1:0]             r_wp;
    logic [PW-1:0]             n_wp;
    logic [CW-1:0]             w_d_ext;
    logic [CW-1:0]             w_d_cl;
    logic [PW-1:0]             w_d_eff;
    logic [PW:0]               w_rp_wrap;
    logic [PW-1:0]             w_rp;
    logic signed [COEF_W-1:0]  w_fb_eff;
    logic [COEF_W-1:0]         w_mix_eff;

    // pipeline stage 1: memory data ready, multiply
    logic                      r_v1;
    logic                      r_en1;
    logic [PW-1:0]             r_wp1;
    t_in_item                  r_x1;

    // pipeline stage 2: round, saturate, write back
    logic                      r_v2;
    logic                      r_en2;
    logic [PW-1:0]             r_wp2;
    t_in_item                  r_x2;
    logic signed [2*SAMPLE_W-1:0] r_pf_l;
    logic signed [2*SAMPLE_W-1:0] r_pf_r;
    logic signed [2*SAMPLE_W+1:0] r_pm_l;
    logic signed [2*SAMPLE_W+1:0] r_pm_r;

    // output register
    logic                      r_ov;
    t_out_item                 r_out;

    // handshake
    logic                      w_adv2;
    logic                      w_free2;
    logic                      w_adv1;
    logic                      w_free1;
    logic                      w_hazard;
    logic                      w_acc;

    // stage 1 products
    logic signed [SAMPLE_W:0]     w_mix_s;
    logic signed [SAMPLE_W:0]     w_diff_l;
    logic signed [SAMPLE_W:0]     w_diff_r;

    // stage 2 sums
    logic signed [ACC_W-1:0]   w_base_l;
    logic signed [ACC_W-1:0]   w_base_r;
    t_out_item                 w_res;

    // register port
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite & pready;
    assign w_cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= RST_ENABLE;
            r_delay  <= RST_DELAY;
            r_fb     <= RST_FB;
            r_mix    <= RST_MIX;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_ENABLE: r_enable <= pwdata[0];
                REG_DELAY:  r_delay  <= pwdata[DELAY_W-1:0];
                REG_FB:     r_fb     <= pwdata[COEF_W-1:0];
                REG_MIX:    r_mix    <= pwdata[COEF_W-1:0];
                default:    r_enable <= r_enable;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (w_cfg_idx)
            REG_ENABLE: prdata = {{(DATA_W-1){1'b0}}, r_enable};
            REG_DELAY:  prdata = {{(DATA_W-DELAY_W){1'b0}}, r_delay};
            REG_FB:     prdata = {{(DATA_W-COEF_W){1'b0}}, r_fb};
            REG_MIX:    prdata = {{(DATA_W-COEF_W){1'b0}}, r_mix};
            default:    prdata = '0;
        endcase
    end

    // clamped coefficients
    always_comb begin
        if (r_fb > FB_LIMIT) begin
            w_fb_eff = FB_LIMIT;
        end else if (r_fb < FB_LIMIT_NEG) begin
            w_fb_eff = FB_LIMIT_NEG;
        end else begin
            w_fb_eff = r_fb;
        end
        w_mix_eff = (r_mix > UNITY) ? UNITY : r_mix;
    end

    // delay clamp and read address behind the write position
    always_comb begin
        w_d_ext = CW'(r_delay);
        if (r_delay == '0) begin
            w_d_cl = CW'(1);
        end else if (w_d_ext > D_MAX) begin
            w_d_cl = D_MAX;
        end else begin
            w_d_cl = w_d_ext;
        end
        w_d_eff   = w_d_cl[PW-1:0];
        w_rp_wrap = {1'b0, r_wp} + DEPTH_X - {1'b0, w_d_eff};
        if (r_wp >= w_d_eff) begin
            w_rp = r_wp - w_d_eff;
        end else begin
            w_rp = w_rp_wrap[PW-1:0];
        end
        n_wp = (r_wp == LAST_POS) ? '0 : r_wp + 1'b1;
    end

    // pipeline flow and read-after-write interlock
    assign w_adv2   = r_v2 & (~r_ov | ~i_out_stall);
    assign w_free2  = ~r_v2 | w_adv2;
    assign w_adv1   = r_v1 & w_free2;
    assign w_free1  = ~r_v1 | w_adv1;
    assign w_hazard = r_enable & ((r_v1 & r_en1 & (r_wp1 == w_rp)) |
                                  (r_v2 & r_en2 & (r_wp2 == w_rp)));
    assign o_in_stall = r_clr_busy | ~w_free1 | w_hazard;
    assign w_acc      = i_in_valid & ~o_in_stall;

    // clearing sweep after reset
    assign n_clr_idx = r_clr_idx + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= n_clr_idx;
            if (r_clr_idx == LAST_POS) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // write position advances on each filtered request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
        end else if (w_acc && r_enable) begin
            r_wp <= n_wp;
        end
    end

    // memory write port shared by the sweep and the write-back
    always_comb begin
        if (r_clr_busy) begin
            w_we   = 1'b1;
            w_wa   = r_clr_idx;
            w_wd_l = '0;
            w_wd_r = '0;
        end else begin
            w_we   = w_adv2 & r_en2;
            w_wa   = r_wp2;
            w_wd_l = round_sat(w_base_l + ACC_W'(r_pf_l));
            w_wd_r = round_sat(w_base_r + ACC_W'(r_pf_r));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_l[w_wa] <= w_wd_l;
            r_mem_r[w_wa] <= w_wd_r;
        end
    end

    // memory read, issued with the request
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rd_l <= r_mem_l[w_rp];
            r_rd_r <= r_mem_r[w_rp];
        end
    end

    // stage 1 control and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_free1) begin
            r_v1 <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_en1 <= r_enable;
            r_wp1 <= r_wp;
            r_x1  <= i_in_data;
        end
    end

    // stage 1 multiplies: feedback term and mix term x + mix * (d - x)
    assign w_mix_s  = signed'({1'b0, w_mix_eff});
    assign w_diff_l = (SAMPLE_W+1)'(r_rd_l) - (SAMPLE_W+1)'(r_x1.left_in);
    assign w_diff_r = (SAMPLE_W+1)'(r_rd_r) - (SAMPLE_W+1)'(r_x1.right_in);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_free2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_en2  <= r_en1;
            r_wp2  <= r_wp1;
            r_x2   <= r_x1;
            r_pf_l <= w_fb_eff * r_rd_l;
            r_pf_r <= w_fb_eff * r_rd_r;
            r_pm_l <= w_mix_s * w_diff_l;
            r_pm_r <= w_mix_s * w_diff_r;
        end
    end

    // stage 2: input scaled to the accumulator, round and saturate, or pass the input through when disabled
    assign w_base_l = ACC_W'(r_x2.left_in) <<< FRAC;
    assign w_base_r = ACC_W'(r_x2.right_in) <<< FRAC;

    always_comb begin
        if (r_en2) begin
            w_res.left_out  = round_sat(w_base_l + ACC_W'(r_pm_l));
            w_res.right_out = round_sat(w_base_r + ACC_W'(r_pm_r));
        end else begin
            w_res.left_out  = r_x2.left_in;
            w_res.right_out = r_x2.right_in;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv2) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // pipeline is empty while the memories are swept
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!r_v1 && !r_v2 && !r_ov))
        else $error("request in flight during memory sweep");

    // two filtered samples in flight never share a write position
    a_distinct_wp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_en1 && r_en2) |-> (r_wp1 != r_wp2))
        else $error("write position reused in flight");

    // a filtered request moves the write position
    a_wp_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_enable) |=> (r_wp != $past(r_wp)))
        else $error("write position did not advance");

    // a new result comes only from the round stage
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_v2))
        else $error("result without a request in the round stage");

endmodule

### sim/stereo_feedback_comb_filter_top_tb.sv
// self-checking testbench for the stereo feedback comb filter: directed table, then random phases
module stereo_feedback_comb_filter_top_tb;
    import sfcf_pkg::*;

    localparam int STORE_DEPTH = 4096;
    localparam int ITEMS_PER_SETTING = 123;
    localparam int SETTINGS_PER_PHASE = 5;

    // one row of the directed table: optional register load, a sample pair,
    // and a typed-in expected pair where it is obvious
    typedef struct packed {
        logic           load;
        logic           en;
        logic [11:0]    dly;
        logic [15:0]    fb;
        logic [15:0]    mix;
        t_sample        lin;
        t_sample        rin;
        logic           known;
        t_sample        exp_l;
        t_sample        exp_r;
    } t_dir_row;

    localparam t_dir_row DIRECTED_ROWS [23] = '{
        // reset settings, stores still zero: output is half the input
        '{1'b0, 1'b1, 12'd120, 16'd16384, 16'd16384, 16'sh7FFF, 16'sh8000,
          1'b1, 16'sd16384, 16'shC000},
        '{1'b0, 1'b1, 12'd120, 16'd16384, 16'd16384, 16'sd0, 16'sd0,
          1'b1, 16'sd0, 16'sd0},
        '{1'b0, 1'b1, 12'd120, 16'd16384, 16'd16384, 16'sd1, 16'shFFFF,
          1'b1, 16'sd1, 16'sd0},
        '{1'b0, 1'b1, 12'd120, 16'd16384, 16'd16384, 16'sh8000, 16'sh7FFF,
          1'b1, 16'shC000, 16'sd16384},
        // pass through
        '{1'b1, 1'b0, 12'd120, 16'd16384, 16'd16384, 16'sh7FFF, 16'sh8000,
          1'b1, 16'sh7FFF, 16'sh8000},
        '{1'b0, 1'b0, 12'd120, 16'd16384, 16'd16384, 16'sh5555, 16'shAAAA,
          1'b1, 16'sh5555, 16'shAAAA},
        // delay one, feedback and mix beyond their limits
        '{1'b1, 1'b1, 12'd1, 16'h7FFF, 16'hFFFF, 16'sh7FFF, 16'sh8000,
          1'b0, 16'sd0, 16'sd0},
        '{1'b0, 1'b1, 12'd1, 16'h7FFF, 16'hFFFF, 16'sh7FFF, 16'sh8000,
          1'b0, 16'sd0, 16'sd0},
        '{1'b0, 1'b1, 12'd1, 16'h7FFF, 16'hFFFF, 16'sh7FFF, 16'sh8000,
          1'b0, 16'sd0, 16'sd0},
        '{1'b0, 1'b1, 12'd1, 16'h7FFF, 16'hFFFF, 16'sd0, 16'sd0,
          1'b0, 16'sd0, 16'sd0},
        // delay zero used as one, most negative feedback, dry mix: output equals input
        '{1'b1, 1'b1, 12'd0, 16'h8000, 16'd0, 16'sh7FFF, 16'sh8000,
          1'b1, 16'sh7FFF, 16'sh8000},
        '{1'b0, 1'b1, 12'd0, 16'h8000, 16'd0, 16'sh8000, 16'sh7FFF,
          1'b1, 16'sh8000, 16'sh7FFF},
        '{1'b0, 1'b1, 12'd0, 16'h8000, 16'd0, 16'sd100, -16'sd100,
          1'b1, 16'sd100, -16'sd100},
        // longest delay, feedback just above the limit, fully wet
        '{1'b1, 1'b1, 12'd4095, 16'h7C2A, 16'h8000, 16'sh7FFF, 16'sh8000,
          1'b0, 16'sd0, 16'sd0},
        '{1'b0, 1'b1, 12'd4095, 16'h7C2A, 16'h8000, 16'sd1, 16'shFFFF,
          1'b0, 16'sd0, 16'sd0},
        '{1'b0, 1'b1, 12'd4095, 16'h7C2A, 16'h8000, 16'sd1234, -16'sd1234,
          1'b0, 16'sd0, 16'sd0},
        // delay two, feedback just below the negative limit, barely wet
        '{1'b1, 1'b1, 12'd2, 16'h83D6, 16'd1, 16'sh7FFF, 16'sh8000,
          1'b0, 16'sd0, 16'sd0},
        '{1'b0, 1'b1, 12'd2, 16'h83D6, 16'd1, 16'sh8000, 16'sh7FFF,
          1'b0, 16'sd0, 16'sd0},
        '{1'b0, 1'b1, 12'd2, 16'h83D6, 16'd1, 16'sd0, 16'sd1,
          1'b0, 16'sd0, 16'sd0},
        // mix just above one
        '{1'b1, 1'b1, 12'd3, 16'h0000, 16'd32769, 16'sh7FFF, 16'sh8000,
          1'b0, 16'sd0, 16'sd0},
        '{1'b0, 1'b1, 12'd3, 16'h0000, 16'd32769, 16'sh4000, 16'shC000,
          1'b0, 16'sd0, 16'sd0},
        // back to reset settings
        '{1'b1, 1'b1, 12'd120, 16'd16384, 16'd16384, 16'sh0F0F, 16'shF0F0,
          1'b0, 16'sd0, 16'sd0},
        '{1'b0, 1'b1, 12'd120, 16'd16384, 16'd16384, 16'sh7FFF, 16'sh7FFF,
          1'b0, 16'sd0, 16'sd0}
    };

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_item             i_in_data   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [ADDR_W-1:0]    paddr       = '0;
    logic [DATA_W-1:0]    pwdata      = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_item            o_out_data;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    stereo_feedback_comb_filter_top #(
        .STORE_DEPTH(STORE_DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // predictor state: delay lines, write pointer and register copies
    t_sample              left_line  [STORE_DEPTH];
    t_sample              right_line [STORE_DEPTH];
    int unsigned          wr_pos;
    logic                 cfg_enable;
    logic [11:0]          cfg_delay;
    logic signed [15:0]   cfg_fb;
    logic [15:0]          cfg_mix;

    t_out_item            expected_pairs [$];
    int                   error_count = 0;
    int                   pairs_sent = 0;
    int                   pairs_checked = 0;
    int                   settings_loaded = 0;
    int unsigned          tx_idle_pct = 0;
    int unsigned          rx_idle_pct = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #3000000;
        $display("stereo_feedback_comb_filter_top_tb: FAIL");
        $finish;
    end

    // Q1.15 round half up, then clip to the sample range
    function automatic t_sample q15_round_clip(input longint v);
        longint q;
        q = (v + 64'sd16384) >>> 15;
        if (q > 32767) begin
            q = 32767;
        end else if (q < -32768) begin
            q = -32768;
        end
        return t_sample'(q[15:0]);
    endfunction

    // filter one stereo pair, updating the delay lines and pointer
    function automatic t_out_item filter_pair(input t_in_item p);
        int unsigned d;
        int unsigned rd;
        longint      fb;
        longint      mix;
        longint      xl;
        longint      xr;
        longint      dl;
        longint      dr;
        t_out_item   r;
        if (!cfg_enable) begin
            r.left_out  = p.left_in;
            r.right_out = p.right_in;
            return r;
        end
        d = cfg_delay;
        if (d < 1) d = 1;
        if (d > STORE_DEPTH - 1) d = STORE_DEPTH - 1;
        fb = cfg_fb;
        if (fb > 31785) fb = 31785;
        if (fb < -31785) fb = -31785;
        mix = cfg_mix;
        if (mix > 32768) mix = 32768;
        xl = p.left_in;
        xr = p.right_in;
        rd = (wr_pos + STORE_DEPTH - d) % STORE_DEPTH;
        dl = left_line[rd];
        dr = right_line[rd];
        left_line[wr_pos]  = q15_round_clip(xl * 32768 + fb * dl);
        right_line[wr_pos] = q15_round_clip(xr * 32768 + fb * dr);
        r.left_out  = q15_round_clip(mix * dl + (32768 - mix) * xl);
        r.right_out = q15_round_clip(mix * dr + (32768 - mix) * xr);
        wr_pos = (wr_pos + 1) % STORE_DEPTH;
        return r;
    endfunction

    function automatic t_sample pick_sample();
        case ($urandom_range(15))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return t_sample'($urandom);
        endcase
    endfunction

    // send one request, waiting out stalls; predict at acceptance
    task automatic send_pair(input t_in_item p, input logic known, input t_out_item typed);
        t_out_item pred;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        do @(posedge i_clk); while (o_in_stall);
        pred = filter_pair(p);
        expected_pairs.insert(expected_pairs.size(), known ? typed : pred);
        pairs_sent++;
    endtask

    // let every outstanding result come back, plus pipeline slack
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_pairs.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // APB write: setup then access, register taken on the access edge
    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_ENABLE: cfg_enable = value[0];
            REG_DELAY:  cfg_delay  = value[11:0];
            REG_FB:     cfg_fb     = value[15:0];
            REG_MIX:    cfg_mix    = value[15:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic en, input logic [11:0] dly,
                                  input logic [15:0] fb, input logic [15:0] mix);
        wait_idle();
        write_reg(REG_ENABLE, {31'd0, en});
        write_reg(REG_DELAY, {20'd0, dly});
        write_reg(REG_FB, {16'd0, fb});
        write_reg(REG_MIX, {16'd0, mix});
        settings_loaded++;
    endtask

    // result checker and receiver stall
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pairs.size() == 0) begin
                $error("unexpected result left_out=%0d right_out=%0d",
                       o_out_data.left_out, o_out_data.right_out);
                error_count++;
            end else begin
                want = expected_pairs.pop_front();
                pairs_checked++;
                if (o_out_data.left_out !== want.left_out) begin
                    $error("left_out expected %0d actual %0d",
                           want.left_out, o_out_data.left_out);
                    error_count++;
                end
                if (o_out_data.right_out !== want.right_out) begin
                    $error("right_out expected %0d actual %0d",
                           want.right_out, o_out_data.right_out);
                    error_count++;
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // main sequence
    initial begin : main_seq
        t_dir_row    row;
        t_in_item    pin;
        t_out_item   pout;
        logic        en;
        logic [11:0] dly;
        logic [15:0] fb;
        logic [15:0] mix;
        for (int k = 0; k < STORE_DEPTH; k++) begin
            left_line[k]  = '0;
            right_line[k] = '0;
        end
        wr_pos     = 0;
        cfg_enable = RST_ENABLE;
        cfg_delay  = RST_DELAY;
        cfg_fb     = RST_FB;
        cfg_mix    = RST_MIX;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, mild idling on both sides
        tx_idle_pct = 10;
        rx_idle_pct = 30;
        foreach (DIRECTED_ROWS[k]) begin
            row = DIRECTED_ROWS[k];
            if (row.load) apply_settings(row.en, row.dly, row.fb, row.mix);
            pin.left_in   = row.lin;
            pin.right_in  = row.rin;
            pout.left_out  = row.exp_l;
            pout.right_out = row.exp_r;
            send_pair(pin, row.known, pout);
        end

        // random phases: slow receiver, then slow sender, then full speed
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 10; rx_idle_pct = 58; end
                1: begin tx_idle_pct = 58; rx_idle_pct = 10; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
                en = ($urandom_range(7) != 0);
                case ($urandom_range(3))
                    0: dly = 12'($urandom_range(4));
                    1: dly = 12'($urandom_range(300, 5));
                    2: dly = 12'($urandom);
                    default: dly = 12'd4095;
                endcase
                if ($urandom_range(2) == 0) begin
                    fb = 16'($urandom);
                end else begin
                    fb = 16'($urandom_range(63570) - 31785);
                end
                if ($urandom_range(3) == 0) begin
                    mix = 16'($urandom);
                end else begin
                    mix = 16'($urandom_range(32768));
                end
                apply_settings(en, dly, fb, mix);
                for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
                    pin.left_in  = pick_sample();
                    pin.right_in = pick_sample();
                    send_pair(pin, 1'b0, '0);
                end
            end
        end

        wait_idle();
        $display("sent %0d sample pairs, checked %0d results over %0d register settings",
                 pairs_sent, pairs_checked, settings_loaded);
        $display("covered pass through, delay and gain clamps, and three idling phases");
        if (error_count == 0) begin
            $display("stereo_feedback_comb_filter_top_tb: PASS");
        end else begin
            $display("stereo_feedback_comb_filter_top_tb: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/sfcf_pkg.sv
rtl/core/stereo_feedback_comb_filter_top.sv
sim/stereo_feedback_comb_filter_top_tb.sv
